[hdl/scm_pkg.sv]
package scm_pkg;

  localparam int REF_DEPTH = 1024;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int CNT_W     = REF_AW + 1;
  localparam int TIME_W    = 32;
  localparam int WIN_W     = 16;
  localparam int QCNT_W    = 32;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int QC_W      = Q_AW + 1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd350;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] event_time;
  } scm_in_t;

  typedef struct packed {
    logic              matched;
    logic [QCNT_W-1:0] query_index;
    logic [REF_AW-1:0] ref_index;
    logic [WIN_W-1:0]  delay;
    logic [CNT_W-1:0]  match_total;
  } scm_out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [TIME_W-1:0] t;
  } scm_cmd_t;

endpackage

[hdl/scm_front.sv]
module scm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  scm_pkg::scm_in_t in_data,
  output logic             q_valid,
  output scm_pkg::scm_cmd_t q_head,
  input  logic             q_pop
);
  import scm_pkg::*;

  scm_cmd_t          q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  logic              accept;
  logic              push;
  scm_cmd_t          cmd;

  assign busy    = (cnt_r == QC_W'(Q_DEPTH));
  assign accept  = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  // classify: unused op code is accepted and dropped here
  always_comb begin
    cmd.t    = in_data.event_time;
    cmd.kind = CMD_APPEND;
    push     = accept;
    case (in_data.op)
      OP_APPEND: cmd.kind = CMD_APPEND;
      OP_QUERY:  cmd.kind = CMD_QUERY;
      OP_CLEAR:  cmd.kind = CMD_CLEAR;
      default:   push     = 1'b0;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop && q_valid})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

[hdl/scm_back.sv]
module scm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  scm_pkg::scm_cmd_t          q_head,
  output logic                       q_pop,
  input  logic                       cfg_we,
  input  logic [scm_pkg::WIN_W-1:0]  cfg_window,
  output logic                       out_valid,
  output scm_pkg::scm_out_t          out_data
);
  import scm_pkg::*;

  logic [TIME_W-1:0] ref_mem [REF_DEPTH];

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  ref_cnt_r, ref_cnt_nxt;
  logic [CNT_W-1:0]  scan_start_r, scan_start_nxt;
  logic [CNT_W-1:0]  match_cnt_r, match_cnt_nxt;
  logic [QCNT_W-1:0] query_cnt_r, query_cnt_nxt;
  logic [WIN_W-1:0]  window_r;
  logic [TIME_W-1:0] qtime_r, qtime_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [REF_AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [TIME_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  scm_out_t          out_r, out_nxt;

  logic              rd_en;
  logic              wr_en;
  logic [TIME_W-1:0] diff;
  logic              hit;

  assign diff = rdata_r - qtime_r;
  assign hit  = cmp_valid_r && (rdata_r > qtime_r) &&
                (diff < {{(TIME_W - WIN_W){1'b0}}, window_r});

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    ref_cnt_nxt    = ref_cnt_r;
    scan_start_nxt = scan_start_r;
    match_cnt_nxt  = match_cnt_r;
    query_cnt_nxt  = query_cnt_r;
    qtime_nxt      = qtime_r;
    addr_nxt       = addr_r;
    cmp_valid_nxt  = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.kind)
            CMD_APPEND: begin
              if (ref_cnt_r < CNT_W'(REF_DEPTH)) begin
                wr_en       = 1'b1;
                ref_cnt_nxt = ref_cnt_r + 1'b1;
              end
            end
            CMD_CLEAR: begin
              ref_cnt_nxt    = '0;
              scan_start_nxt = '0;
              match_cnt_nxt  = '0;
              query_cnt_nxt  = '0;
            end
            CMD_QUERY: begin
              qtime_nxt = q_head.t;
              addr_nxt  = scan_start_r;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // read of entry addr_r overlaps the compare of the entry before it
        if (hit) begin
          out_valid_nxt        = 1'b1;
          out_nxt.matched      = 1'b1;
          out_nxt.query_index  = query_cnt_r;
          out_nxt.ref_index    = cmp_idx_r;
          out_nxt.delay        = diff[WIN_W-1:0];
          out_nxt.match_total  = match_cnt_r + 1'b1;
          match_cnt_nxt        = match_cnt_r + 1'b1;
          scan_start_nxt       = {1'b0, cmp_idx_r} + 1'b1;
          query_cnt_nxt        = query_cnt_r + 1'b1;
          state_nxt            = ST_IDLE;
        end else if (addr_r < ref_cnt_r) begin
          rd_en         = 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = addr_r[REF_AW-1:0];
          addr_nxt      = addr_r + 1'b1;
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.matched      = 1'b0;
          out_nxt.query_index  = query_cnt_r;
          out_nxt.ref_index    = '0;
          out_nxt.delay        = '0;
          out_nxt.match_total  = match_cnt_r;
          query_cnt_nxt        = query_cnt_r + 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ref_cnt_r    <= '0;
      scan_start_r <= '0;
      match_cnt_r  <= '0;
      query_cnt_r  <= '0;
      window_r     <= WINDOW_RESET;
      cmp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ref_cnt_r    <= ref_cnt_nxt;
      scan_start_r <= scan_start_nxt;
      match_cnt_r  <= match_cnt_nxt;
      query_cnt_r  <= query_cnt_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        window_r <= cfg_window;
      end
    end
  end

  always_ff @(posedge clk) begin
    qtime_r   <= qtime_nxt;
    addr_r    <= addr_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_mem[ref_cnt_r[REF_AW-1:0]] <= q_head.t;
    end
    if (rd_en) begin
      rdata_r <= ref_mem[addr_r[REF_AW-1:0]];
    end
  end

  a_strobe_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SCAN))
    else $error("result strobe without a scan");

  a_scan_within_list: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start_r <= ref_cnt_r)
    else $error("scan start beyond stored entries");

  a_matches_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= scan_start_r)
    else $error("more matches than consumed entries");

  a_hit_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.matched) |-> (out_r.delay != '0))
    else $error("match reported with zero delay");

endmodule

[hdl/spike_coincidence_matcher.sv]
// Coincidence matcher. Items are taken when start is high and busy is low; a
// two-beat command queue decouples intake from execution, so busy only rises
// when the queue is full. Appends and clears execute directly from idle. A
// query examines the stored entries from the entry after the last match up to
// the first hit or the end of the list; the reference store has a single read
// port, read one entry per cycle. Each query yields exactly one result, shown
// for a single cycle with out_valid; the receiver cannot stall it, so it must
// sample out_data whenever out_valid is high. Appends and clears produce no
// result. The window register accepts writes at any time (cfg_ready is always
// high) and should be changed only while idle.
module spike_coincidence_matcher (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  scm_pkg::scm_in_t          in_data,
  output logic                      out_valid,
  output scm_pkg::scm_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [scm_pkg::WIN_W-1:0] cfg_window
);
  import scm_pkg::*;

  logic     q_valid;
  logic     q_pop;
  scm_cmd_t q_head;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  scm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  scm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_window (cfg_window),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
